// ----- rtl/core/pseu_pkg.sv -----
`default_nettype none

package pseu_pkg;

   // configuration port geometry
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 32;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_VELOCITY_RULE         = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SHARED_RANDOM         = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_INERTIA_FACTOR        = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_COGNITIVE_GAIN        = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SOCIAL_GAIN           = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MAX_VELOCITY_FRACTION = 3'd5;

   // velocity rule codes
   localparam logic RULE_INERTIA      = 1'b0;
   localparam logic RULE_CONSTRICTION = 1'b1;

   // register reset values
   localparam logic        RST_VELOCITY_RULE         = RULE_CONSTRICTION;
   localparam logic        RST_SHARED_RANDOM         = 1'b0;
   localparam logic [16:0] RST_INERTIA_FACTOR        = 17'd47710;
   localparam logic [18:0] RST_COGNITIVE_GAIN        = 19'd134349;
   localparam logic [18:0] RST_SOCIAL_GAIN           = 19'd134349;
   localparam logic [16:0] RST_MAX_VELOCITY_FRACTION = 17'd32768;

   // saturation limits in the wide intermediate format
   localparam logic signed [35:0] SAT_HI = 36'sd2147483647;
   localparam logic signed [35:0] SAT_LO = -36'sd2147483648;

   typedef struct packed {
      logic signed [31:0] velocity_in;
      logic signed [31:0] position_in;
      logic signed [31:0] personal_best;
      logic signed [31:0] neighbour_best;
      logic [15:0]        rand_cognitive;
      logic [15:0]        rand_social;
      logic signed [31:0] lower_bound;
      logic signed [31:0] upper_bound;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] velocity_out;
      logic signed [31:0] position_out;
      logic               bound_hit;
   } rsp_payload_type;

   typedef struct packed {
      logic        velocity_rule;
      logic        shared_random;
      logic [16:0] inertia_factor;
      logic [18:0] cognitive_gain;
      logic [18:0] social_gain;
      logic [16:0] max_velocity_fraction;
   } cfg_type;

   // sign extend a Q16.16 value into the wide intermediate format
   function automatic logic signed [35:0] ext36(input logic signed [31:0] x);
      return {{4{x[31]}}, x};
   endfunction

   // clip a wide intermediate to the signed 32-bit range
   function automatic logic signed [31:0] sat32(input logic signed [35:0] x);
      logic signed [31:0] r;
      if (x > SAT_HI) begin
         r = 32'sh7FFFFFFF;
      end else if (x < SAT_LO) begin
         r = 32'sh80000000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/pseu_csr.sv -----
`default_nettype none

module pseu_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [pseu_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [pseu_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   output pseu_pkg::cfg_type                         cfg
);
   import pseu_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // writes are always taken, csr_ready is tied high
   assign csr_ready = 1'b1;

   // decode the register index, unknown indexes leave everything as is
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_VELOCITY_RULE:         cfg_in.velocity_rule         = csr_wdata[0];
            REG_SHARED_RANDOM:         cfg_in.shared_random         = csr_wdata[0];
            REG_INERTIA_FACTOR:        cfg_in.inertia_factor        = csr_wdata[16:0];
            REG_COGNITIVE_GAIN:        cfg_in.cognitive_gain        = csr_wdata[18:0];
            REG_SOCIAL_GAIN:           cfg_in.social_gain           = csr_wdata[18:0];
            REG_MAX_VELOCITY_FRACTION: cfg_in.max_velocity_fraction = csr_wdata[16:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.velocity_rule         <= RST_VELOCITY_RULE;
         cfg_ff.shared_random         <= RST_SHARED_RANDOM;
         cfg_ff.inertia_factor        <= RST_INERTIA_FACTOR;
         cfg_ff.cognitive_gain        <= RST_COGNITIVE_GAIN;
         cfg_ff.social_gain           <= RST_SOCIAL_GAIN;
         cfg_ff.max_velocity_fraction <= RST_MAX_VELOCITY_FRACTION;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ----- rtl/core/pso_particle_element_update.sv -----
`default_nettype none

// Particle swarm coordinate update. Each request transaction carries one
// coordinate of one particle (velocity, position, personal and neighbourhood
// best, two random fractions, bounds) and yields exactly one response with the
// new velocity, the new position and a bound-hit flag, in request order. The
// datapath is a six-stage pipeline: gains and differences, attraction and
// limit products, term sums, constriction product, velocity clamp, position
// clamp into the output register. A new transaction is taken every cycle
// unless back-pressure from rsp_stall fills the pipeline. Stall propagates
// stage by stage, so empty stages keep filling while the response is held.
// The user must write configuration over csr only while no transaction is
// in flight; the block does not enforce this. Unknown indexes are ignored.

module pso_particle_element_update (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire pseu_pkg::req_payload_type            req_payload,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output pseu_pkg::rsp_payload_type                 rsp_payload,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [pseu_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [pseu_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);
   import pseu_pkg::*;

   localparam int NUM_STAGES = 6;

   cfg_type cfg;

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] load;

   // configuration registers
   pseu_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // per-stage flow control, a stage loads when empty or when it drains
   always_comb begin
      load[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || !rsp_stall;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         load[k] = !valid_ff[k] || load[k+1];
      end
      valid_in = valid_ff;
      if (load[0]) begin
         valid_in[0] = req_valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
         if (load[k]) begin
            valid_in[k] = valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !load[0];
   assign rsp_valid = valid_ff[NUM_STAGES-1];

   // stage 1: gain products, differences, bound width, inertia product
   logic [15:0]        s1_r2;
   logic [34:0]        s1_g1_prod;
   logic [34:0]        s1_g2_prod;
   logic [18:0]        s1_g1_ff, s1_g2_ff;
   logic signed [32:0] s1_d1_ff, s1_d1_in;
   logic signed [32:0] s1_d2_ff, s1_d2_in;
   logic signed [32:0] s1_dw_ff, s1_dw_in;
   logic signed [48:0] s1_wv_ff, s1_wv_in;
   logic signed [31:0] s1_v_ff, s1_x_ff, s1_lb_ff, s1_ub_ff;

   always_comb begin
      s1_r2      = cfg.shared_random ? req_payload.rand_cognitive : req_payload.rand_social;
      s1_g1_prod = 35'(cfg.cognitive_gain) * 35'(req_payload.rand_cognitive);
      s1_g2_prod = 35'(cfg.social_gain) * 35'(s1_r2);
      s1_d1_in   = $signed({req_payload.personal_best[31], req_payload.personal_best})
                 - $signed({req_payload.position_in[31], req_payload.position_in});
      s1_d2_in   = $signed({req_payload.neighbour_best[31], req_payload.neighbour_best})
                 - $signed({req_payload.position_in[31], req_payload.position_in});
      s1_dw_in   = $signed({req_payload.upper_bound[31], req_payload.upper_bound})
                 - $signed({req_payload.lower_bound[31], req_payload.lower_bound});
      s1_wv_in   = 49'($signed({1'b0, cfg.inertia_factor}))
                 * 49'($signed(req_payload.velocity_in));
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         s1_g1_ff <= s1_g1_prod[34:16];
         s1_g2_ff <= s1_g2_prod[34:16];
         s1_d1_ff <= s1_d1_in;
         s1_d2_ff <= s1_d2_in;
         s1_dw_ff <= s1_dw_in;
         s1_wv_ff <= s1_wv_in;
         s1_v_ff  <= req_payload.velocity_in;
         s1_x_ff  <= req_payload.position_in;
         s1_lb_ff <= req_payload.lower_bound;
         s1_ub_ff <= req_payload.upper_bound;
      end
   end

   // stage 2: attraction products, limit product, scaled inertia term
   logic signed [51:0] s2_m1_ff, s2_m1_in;
   logic signed [51:0] s2_m2_ff, s2_m2_in;
   logic signed [49:0] s2_ml_ff, s2_ml_in;
   logic signed [31:0] s2_iw_ff, s2_iw_in;
   logic signed [31:0] s2_v_ff, s2_x_ff, s2_lb_ff, s2_ub_ff;

   always_comb begin
      s2_m1_in = 52'(s1_d1_ff) * 52'($signed({1'b0, s1_g1_ff}));
      s2_m2_in = 52'(s1_d2_ff) * 52'($signed({1'b0, s1_g2_ff}));
      s2_ml_in = 50'(s1_dw_ff) * 50'($signed({1'b0, cfg.max_velocity_fraction}));
      s2_iw_in = sat32($signed({{3{s1_wv_ff[48]}}, s1_wv_ff[48:16]}));
   end

   always_ff @(posedge clock) begin
      if (load[1]) begin
         s2_m1_ff <= s2_m1_in;
         s2_m2_ff <= s2_m2_in;
         s2_ml_ff <= s2_ml_in;
         s2_iw_ff <= s2_iw_in;
         s2_v_ff  <= s1_v_ff;
         s2_x_ff  <= s1_x_ff;
         s2_lb_ff <= s1_lb_ff;
         s2_ub_ff <= s1_ub_ff;
      end
   end

   // stage 3: saturate terms and form the velocity sum for the chosen rule
   logic signed [31:0] s3_t1, s3_t2, s3_nv0, s3_sum;
   logic signed [31:0] s3_pre_ff, s3_pre_in;
   logic signed [33:0] s3_lim_ff;
   logic signed [31:0] s3_x_ff, s3_lb_ff, s3_ub_ff;

   always_comb begin
      s3_t1     = sat32($signed(s2_m1_ff[51:16]));
      s3_t2     = sat32($signed(s2_m2_ff[51:16]));
      s3_nv0    = sat32(ext36(s2_iw_ff) + ext36(s3_t1) + ext36(s3_t2));
      s3_sum    = sat32(ext36(s2_v_ff) + ext36(s3_t1) + ext36(s3_t2));
      s3_pre_in = (cfg.velocity_rule == RULE_CONSTRICTION) ? s3_sum : s3_nv0;
   end

   always_ff @(posedge clock) begin
      if (load[2]) begin
         s3_pre_ff <= s3_pre_in;
         s3_lim_ff <= s2_ml_ff[49:16];
         s3_x_ff   <= s2_x_ff;
         s3_lb_ff  <= s2_lb_ff;
         s3_ub_ff  <= s2_ub_ff;
      end
   end

   // stage 4: constriction product
   logic signed [48:0] s4_ws_ff, s4_ws_in;
   logic signed [31:0] s4_pre_ff;
   logic signed [33:0] s4_lim_ff;
   logic signed [31:0] s4_x_ff, s4_lb_ff, s4_ub_ff;

   assign s4_ws_in = 49'($signed({1'b0, cfg.inertia_factor})) * 49'(s3_pre_ff);

   always_ff @(posedge clock) begin
      if (load[3]) begin
         s4_ws_ff  <= s4_ws_in;
         s4_pre_ff <= s3_pre_ff;
         s4_lim_ff <= s3_lim_ff;
         s4_x_ff   <= s3_x_ff;
         s4_lb_ff  <= s3_lb_ff;
         s4_ub_ff  <= s3_ub_ff;
      end
   end

   // stage 5: pick the rule result and clamp to the velocity limit
   logic signed [31:0] s5_raw;
   logic signed [35:0] s5_raw36, s5_lim36, s5_nlim36, s5_sel;
   logic signed [31:0] s5_nv_ff, s5_nv_in;
   logic signed [31:0] s5_x_ff, s5_lb_ff, s5_ub_ff;

   always_comb begin
      s5_raw    = (cfg.velocity_rule == RULE_CONSTRICTION)
                ? sat32($signed({{3{s4_ws_ff[48]}}, s4_ws_ff[48:16]})) : s4_pre_ff;
      s5_raw36  = ext36(s5_raw);
      s5_lim36  = $signed({{2{s4_lim_ff[33]}}, s4_lim_ff});
      s5_nlim36 = -s5_lim36;
      if (s5_raw36 > s5_lim36) begin
         s5_sel = s5_lim36;
      end else if (s5_raw36 < s5_nlim36) begin
         s5_sel = s5_nlim36;
      end else begin
         s5_sel = s5_raw36;
      end
      s5_nv_in = sat32(s5_sel);
   end

   always_ff @(posedge clock) begin
      if (load[4]) begin
         s5_nv_ff <= s5_nv_in;
         s5_x_ff  <= s4_x_ff;
         s5_lb_ff <= s4_lb_ff;
         s5_ub_ff <= s4_ub_ff;
      end
   end

   // stage 6: move and clamp the position, lower bound checked first
   logic signed [32:0] s6_nx, s6_lb, s6_ub;
   rsp_payload_type    rsp_ff, rsp_in;

   always_comb begin
      s6_nx = $signed({s5_x_ff[31], s5_x_ff}) + $signed({s5_nv_ff[31], s5_nv_ff});
      s6_lb = $signed({s5_lb_ff[31], s5_lb_ff});
      s6_ub = $signed({s5_ub_ff[31], s5_ub_ff});
      priority if (s6_nx < s6_lb) begin
         rsp_in.position_out = s5_lb_ff;
         rsp_in.velocity_out = '0;
         rsp_in.bound_hit    = 1'b1;
      end else if (s6_nx > s6_ub) begin
         rsp_in.position_out = s5_ub_ff;
         rsp_in.velocity_out = '0;
         rsp_in.bound_hit    = 1'b1;
      end else begin
         rsp_in.position_out = s6_nx[31:0];
         rsp_in.velocity_out = s5_nv_ff;
         rsp_in.bound_hit    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load[5]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

// ----- tb/pseu_update_checker.sv -----
module pseu_update_checker (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   input  wire logic                                 req_stall,
   input  wire pseu_pkg::req_payload_type            req_payload,
   input  wire logic                                 rsp_valid,
   input  wire logic                                 rsp_stall,
   input  wire pseu_pkg::rsp_payload_type            rsp_payload,
   input  wire logic                                 csr_valid,
   input  wire logic                                 csr_ready,
   input  wire logic [pseu_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [pseu_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   output int                                        failures,
   output int                                        outstanding,
   output int                                        checked
);

   timeunit 1ns;
   timeprecision 1ps;

   import pseu_pkg::*;

   localparam longint Q_HI = 64'sd2147483647;
   localparam longint Q_LO = -64'sd2147483648;

   // register copy kept in step with the csr channel
   cfg_type shadow;

   // updates predicted for accepted transactions, oldest first
   rsp_payload_type pending_coords[$];

   // clip to the signed 32-bit range
   function automatic longint clip_q16(input longint a);
      if (a > Q_HI) begin
         return Q_HI;
      end else if (a < Q_LO) begin
         return Q_LO;
      end
      return a;
   endfunction

   // new velocity and position for one coordinate under the given registers
   function automatic rsp_payload_type next_coordinate(input req_payload_type p,
                                                       input cfg_type c);
      longint v, x, pb, nb, lb, ub, w, g_cog, g_soc, t_cog, t_soc, nv, lim, nx;
      logic [15:0] r_soc;
      rsp_payload_type o;
      v  = longint'($signed(p.velocity_in));
      x  = longint'($signed(p.position_in));
      pb = longint'($signed(p.personal_best));
      nb = longint'($signed(p.neighbour_best));
      lb = longint'($signed(p.lower_bound));
      ub = longint'($signed(p.upper_bound));
      w  = longint'(c.inertia_factor);
      r_soc = c.shared_random ? p.rand_cognitive : p.rand_social;

      // effective gains, then pull toward personal and neighbourhood best
      g_cog = (longint'(c.cognitive_gain) * longint'(p.rand_cognitive)) >>> 16;
      g_soc = (longint'(c.social_gain) * longint'(r_soc)) >>> 16;
      t_cog = clip_q16(((pb - x) * g_cog) >>> 16);
      t_soc = clip_q16(((nb - x) * g_soc) >>> 16);

      if (c.velocity_rule == RULE_INERTIA) begin
         nv = clip_q16(clip_q16((w * v) >>> 16) + t_cog + t_soc);
      end else begin
         nv = clip_q16((w * clip_q16(v + t_cog + t_soc)) >>> 16);
      end

      // velocity limit from the bound width
      lim = ((ub - lb) * longint'(c.max_velocity_fraction)) >>> 16;
      if (nv > lim) begin
         nv = lim;
      end else if (nv < -lim) begin
         nv = -lim;
      end
      nv = clip_q16(nv);

      // move and clamp into the bounds, lower bound first
      nx = x + nv;
      o.bound_hit = 1'b0;
      if (nx < lb) begin
         nx = lb;
         nv = 0;
         o.bound_hit = 1'b1;
      end else if (nx > ub) begin
         nx = ub;
         nv = 0;
         o.bound_hit = 1'b1;
      end
      o.velocity_out = nv[31:0];
      o.position_out = nx[31:0];
      return o;
   endfunction

   // watch all three channels at the clock edge
   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         shadow.velocity_rule         <= RST_VELOCITY_RULE;
         shadow.shared_random         <= RST_SHARED_RANDOM;
         shadow.inertia_factor        <= RST_INERTIA_FACTOR;
         shadow.cognitive_gain        <= RST_COGNITIVE_GAIN;
         shadow.social_gain           <= RST_SOCIAL_GAIN;
         shadow.max_velocity_fraction <= RST_MAX_VELOCITY_FRACTION;
         pending_coords.delete();
         outstanding <= 0;
      end else begin
         // register writes, unknown indexes dropped
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_VELOCITY_RULE:         shadow.velocity_rule <= csr_wdata[0];
               REG_SHARED_RANDOM:         shadow.shared_random <= csr_wdata[0];
               REG_INERTIA_FACTOR:        shadow.inertia_factor <= csr_wdata[16:0];
               REG_COGNITIVE_GAIN:        shadow.cognitive_gain <= csr_wdata[18:0];
               REG_SOCIAL_GAIN:           shadow.social_gain <= csr_wdata[18:0];
               REG_MAX_VELOCITY_FRACTION: shadow.max_velocity_fraction <= csr_wdata[16:0];
               default: ;
            endcase
         end

         // predict each accepted request transaction
         if (req_valid && !req_stall) begin
            pending_coords = {pending_coords, next_coordinate(req_payload, shadow)};
         end

         // compare each accepted response transaction with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (pending_coords.size() == 0) begin
               $error("response transaction with no request pending");
               failures++;
            end else begin
               want = pending_coords.pop_front();
               checked++;
               if (rsp_payload.velocity_out !== want.velocity_out) begin
                  $error("velocity_out mismatch: expected %0d, got %0d",
                         $signed(want.velocity_out), $signed(rsp_payload.velocity_out));
                  failures++;
               end
               if (rsp_payload.position_out !== want.position_out) begin
                  $error("position_out mismatch: expected %0d, got %0d",
                         $signed(want.position_out), $signed(rsp_payload.position_out));
                  failures++;
               end
               if (rsp_payload.bound_hit !== want.bound_hit) begin
                  $error("bound_hit mismatch: expected %0b, got %0b",
                         want.bound_hit, rsp_payload.bound_hit);
                  failures++;
               end
            end
         end
         outstanding <= pending_coords.size();
      end
   end

endmodule

// ----- tb/tb_pso_particle_element_update.sv -----
module tb_pso_particle_element_update;

   timeunit 1ns;
   timeprecision 1ps;

   import pseu_pkg::*;

   localparam int CYCLE_LIMIT     = 200000;
   localparam int PHASES          = 9;
   localparam int ITEMS_PER_PHASE = 160;
   localparam int DRAIN_CYCLES    = 12;

   // indexes that map to no register
   localparam logic [CSR_INDEX_WIDTH-1:0] IDX_UNUSED_LO = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] IDX_UNUSED_HI = 3'd7;

   localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;
   localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_payload_type req_payload;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;
   logic csr_valid;
   logic csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata;

   int failures;
   int outstanding;
   int checked;
   int idle_pct = 0;
   int stall_pct = 0;
   int items_sent = 0;
   int settings_used = 1;
   int unsigned cycle_count = 0;

   always #5ns clock = ~clock;

   pso_particle_element_update dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   pseu_update_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .failures    (failures),
      .outstanding (outstanding),
      .checked     (checked)
   );

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
   end

   // run watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Q16.16 value, mostly scaled random with a few corner values
   function automatic logic signed [31:0] pick_q16();
      logic signed [31:0] r;
      if ($urandom_range(7) == 0) begin
         case ($urandom_range(4))
            0: r = Q_MIN;
            1: r = Q_MAX;
            2: r = 32'sh0;
            3: r = -32'sd1;
            default: r = Q_ONE;
         endcase
      end else begin
         r = $signed($urandom) >>> $urandom_range(31);
      end
      return r;
   endfunction

   // coordinate inside ordered bounds with bests inside too; optionally bounds swapped
   function automatic req_payload_type shaped_item(input bit reversed);
      req_payload_type p;
      longint lo, span;
      lo = longint'(pick_q16());
      span = longint'($urandom >> $urandom_range(31));
      if (lo + span > 64'sd2147483647) begin
         span = 64'sd2147483647 - lo;
      end
      p.lower_bound    = 32'(lo);
      p.upper_bound    = 32'(lo + span);
      p.position_in    = 32'(lo + longint'($urandom) % (span + 1));
      p.personal_best  = 32'(lo + longint'($urandom) % (span + 1));
      p.neighbour_best = 32'(lo + longint'($urandom) % (span + 1));
      p.velocity_in    = pick_q16();
      p.rand_cognitive = 16'($urandom);
      p.rand_social    = 16'($urandom);
      if (reversed) begin
         p.lower_bound = 32'(lo + span);
         p.upper_bound = 32'(lo);
      end
      return p;
   endfunction

   // unrelated values in every field
   function automatic req_payload_type noise_item();
      req_payload_type p;
      p.velocity_in    = pick_q16();
      p.position_in    = pick_q16();
      p.personal_best  = pick_q16();
      p.neighbour_best = pick_q16();
      p.rand_cognitive = 16'($urandom);
      p.rand_social    = 16'($urandom);
      p.lower_bound    = pick_q16();
      p.upper_bound    = pick_q16();
      return p;
   endfunction

   function automatic req_payload_type coord(input logic signed [31:0] v, x, pb, nb,
                                             input logic [15:0] r1, r2,
                                             input logic signed [31:0] lb, ub);
      req_payload_type p;
      p.velocity_in    = v;
      p.position_in    = x;
      p.personal_best  = pb;
      p.neighbour_best = nb;
      p.rand_cognitive = r1;
      p.rand_social    = r2;
      p.lower_bound    = lb;
      p.upper_bound    = ub;
      return p;
   endfunction

   // one request transaction, with an optional idle gap ahead of it
   task automatic send_item(input req_payload_type item);
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   // hold off until every predicted response has come back
   task automatic wait_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // one csr transaction; valid is left high for a following write
   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic configure(input logic [31:0] rule, shared, omega, c_cog, c_soc, frac);
      write_csr(REG_VELOCITY_RULE, rule);
      write_csr(REG_SHARED_RANDOM, shared);
      write_csr(REG_INERTIA_FACTOR, omega);
      write_csr(REG_COGNITIVE_GAIN, c_cog);
      write_csr(REG_SOCIAL_GAIN, c_soc);
      write_csr(REG_MAX_VELOCITY_FRACTION, frac);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // field extremes, saturation, reversed and equal bounds, bound hits, zero randoms
   task automatic run_directed();
      send_item(coord(0, 0, 0, 0, 16'h0, 16'h0, 0, 0));
      send_item(coord(Q_MAX, Q_MIN, Q_MAX, Q_MAX, 16'hFFFF, 16'hFFFF, Q_MIN, Q_MAX));
      send_item(coord(Q_MIN, Q_MAX, Q_MIN, Q_MIN, 16'hFFFF, 16'hFFFF, Q_MIN, Q_MAX));
      send_item(coord(Q_MAX, Q_MAX, Q_MAX, Q_MAX, 16'hFFFF, 16'hFFFF, Q_MAX, Q_MAX));
      send_item(coord(Q_MIN, Q_MIN, Q_MIN, Q_MIN, 16'h0, 16'h0, Q_MIN, Q_MIN));
      send_item(coord(5 * Q_ONE, 0, 2 * Q_ONE, -3 * Q_ONE, 16'h8000, 16'h4000,
                      100 * Q_ONE, -100 * Q_ONE));
      send_item(coord(Q_ONE, 0, Q_MAX, Q_MIN, 16'hFFFF, 16'h0, Q_MAX, Q_MIN));
      send_item(coord(3 * Q_ONE, Q_ONE, 2 * Q_ONE, 0, 16'h1234, 16'hABCD, Q_ONE, Q_ONE));
      send_item(coord(50 * Q_ONE, 90 * Q_ONE, 100 * Q_ONE, 100 * Q_ONE, 16'hFFFF,
                      16'hFFFF, -100 * Q_ONE, 100 * Q_ONE));
      send_item(coord(-50 * Q_ONE, -90 * Q_ONE, -100 * Q_ONE, -100 * Q_ONE, 16'hFFFF,
                      16'hFFFF, -100 * Q_ONE, 100 * Q_ONE));
      send_item(coord(3 * Q_ONE, Q_ONE, 40 * Q_ONE, -40 * Q_ONE, 16'h0, 16'h0,
                      -1000 * Q_ONE, 1000 * Q_ONE));
      send_item(coord(-Q_ONE, 0, 10 * Q_ONE, -10 * Q_ONE, 16'hFFFF, 16'h0,
                      -1000 * Q_ONE, 1000 * Q_ONE));
   endtask

   initial begin
      int pick;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      csr_valid   = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      idle_pct    = 23;
      stall_pct   = 77;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset register values first
      run_directed();

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph / 3)
            0: begin
               idle_pct  = 23;
               stall_pct = 77;
            end
            1: begin
               idle_pct  = 77;
               stall_pct = 23;
            end
            default: begin
               idle_pct  = 0;
               stall_pct = 0;
            end
         endcase
         wait_results();

         case (ph)
            0: configure(32'(RULE_INERTIA), 0, 65536, 262144, 262144, 65536);
            1: configure(32'(RULE_CONSTRICTION), 1, 0, 0, 0, 1);
            2: configure(32'(RULE_INERTIA), 1, $urandom_range(65536),
                         $urandom_range(262144), $urandom_range(262144),
                         $urandom_range(65536, 1));
            3: configure(32'(RULE_CONSTRICTION), 0, $urandom_range(65536),
                         $urandom_range(262144), $urandom_range(262144),
                         $urandom_range(65536, 1));
            4: begin
               // ignored indexes, then all-ones words masked down to each register
               write_csr(IDX_UNUSED_LO, $urandom);
               write_csr(IDX_UNUSED_HI, $urandom);
               configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                         32'hFFFF_FFFF, 32'hFFFF_FFFF);
            end
            5: configure(32'(RULE_INERTIA), 0, $urandom_range(65536),
                         $urandom_range(262144), $urandom_range(262144), 0);
            default: configure($urandom, $urandom, $urandom, $urandom, $urandom,
                               $urandom);
         endcase

         // zero velocity fraction under the inertia rule
         if (ph == 5) begin
            run_directed();
         end

         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            pick = $urandom_range(99);
            if (pick < 65) begin
               send_item(shaped_item(1'b0));
            end else if (pick < 75) begin
               send_item(shaped_item(1'b1));
            end else begin
               send_item(noise_item());
            end
            if ($urandom_range(149) == 0) begin
               wait_results();
            end
         end
      end

      wait_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d coordinate updates under %0d register settings,", items_sent,
               settings_used);
      $display("%0d responses compared, %0d mismatches", checked, failures);
      if (failures == 0 && outstanding == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
